// ----- sv/tss_pkg.sv -----
// Shared types, codes and helpers for the traffic signal sequencer.
`timescale 1ns / 1ps
`default_nettype none
package tss_pkg;

  localparam int TIME_BITS      = 6;
  localparam int LEVEL_BITS     = 10;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 10;

  localparam logic [TIME_BITS-1:0] NIGHT_NS_GREEN = TIME_BITS'(8);

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_DAY_THRESHOLD  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_YELLOW_TIME    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NS_GREEN_DAY   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_EW_GREEN_DAY   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_EW_GREEN_NIGHT = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LEFT_GREEN     = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PED_NS_TIME    = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PED_EW_TIME    = 3'd7;

  // Lamp colours
  localparam logic [1:0] LAMP_OFF    = 2'd0;
  localparam logic [1:0] LAMP_RED    = 2'd1;
  localparam logic [1:0] LAMP_GREEN  = 2'd2;
  localparam logic [1:0] LAMP_YELLOW = 2'd3;

  // Timed approach codes
  localparam logic [1:0] APPR_NS      = 2'd0;
  localparam logic [1:0] APPR_NS_TURN = 2'd1;
  localparam logic [1:0] APPR_EW      = 2'd2;
  localparam logic [1:0] APPR_EW_TURN = 2'd3;

  typedef enum logic [10:0] {
    PH_START      = 11'b000_0000_0001,
    PH_NS_WALK    = 11'b000_0000_0010,
    PH_NS_GREEN   = 11'b000_0000_0100,
    PH_NS_YEL     = 11'b000_0000_1000,
    PH_EWLT_GREEN = 11'b000_0001_0000,
    PH_EWLT_YEL   = 11'b000_0010_0000,
    PH_EW_WALK    = 11'b000_0100_0000,
    PH_EW_GREEN   = 11'b000_1000_0000,
    PH_EW_YEL     = 11'b001_0000_0000,
    PH_NSLT_GREEN = 11'b010_0000_0000,
    PH_NSLT_YEL   = 11'b100_0000_0000
  } phase_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] day_threshold;
    logic [TIME_BITS-1:0]  yellow_time;
    logic [TIME_BITS-1:0]  ns_green_day;
    logic [TIME_BITS-1:0]  ew_green_day;
    logic [TIME_BITS-1:0]  ew_green_night;
    logic [TIME_BITS-1:0]  left_green;
    logic [TIME_BITS-1:0]  ped_ns_time;
    logic [TIME_BITS-1:0]  ped_ew_time;
  } tss_cfg_t;

  // Phase controller view of the current tick
  typedef struct packed {
    phase_t               phase;
    logic [TIME_BITS-1:0] secs;
    logic                 day;
  } tss_tick_t;

  typedef struct packed {
    logic [1:0] ns_lamp;
    logic [1:0] ns_turn_lamp;
    logic [1:0] ew_lamp;
    logic [1:0] ew_turn_lamp;
    logic [1:0] timed_approach;
    logic [5:0] seconds_shown;
    logic       walk_side;
    logic [5:0] walk_count;
    logic       buzzer_on;
    logic       day_active;
  } tss_result_t;

  // A zero duration runs as one second
  function automatic logic [TIME_BITS-1:0] dur(input logic [TIME_BITS-1:0] t);
    dur = (t == '0) ? TIME_BITS'(1) : t;
  endfunction

endpackage
`default_nettype wire

// ----- sv/tss_phase_ctl.sv -----
// Phase sequencing and interval timing for the traffic signal sequencer.
`timescale 1ns / 1ps
`default_nettype none
module tss_phase_ctl
  import tss_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  tick,
  input  wire tss_cfg_t              cfg,
  input  wire logic [LEVEL_BITS-1:0] light_level,
  input  wire logic                  ns_walk_req,
  input  wire logic                  ns_turn_req,
  input  wire logic                  ew_walk_req,
  input  wire logic                  ew_turn_req,
  output tss_tick_t                  cur
);

  phase_t               phase_r, phase_nxt;
  logic [TIME_BITS-1:0] secs_r, secs_nxt;
  logic                 day_r, day_nxt;

  logic                 reload;
  logic                 day_new;
  phase_t               start_ph;
  phase_t               adv_ph;
  logic                 adv_start;
  logic [TIME_BITS-1:0] ph_time;
  logic [TIME_BITS-1:0] secs_cur;

  assign reload   = (secs_r == '0) || (phase_r == PH_START);
  assign day_new  = light_level < cfg.day_threshold;
  assign start_ph = (day_new && ns_walk_req) ? PH_NS_WALK : PH_NS_GREEN;

  always_comb begin
    adv_ph    = start_ph;
    adv_start = 1'b0;
    case (phase_r)
      PH_NS_WALK:    adv_ph = PH_NS_GREEN;
      PH_NS_GREEN:   adv_ph = PH_NS_YEL;
      PH_NS_YEL: begin
        if (ew_turn_req) adv_ph = PH_EWLT_GREEN;
        else if (day_r && ew_walk_req) adv_ph = PH_EW_WALK;
        else adv_ph = PH_EW_GREEN;
      end
      PH_EWLT_GREEN: adv_ph = PH_EWLT_YEL;
      PH_EWLT_YEL: begin
        if (day_r) begin
          adv_ph = ew_walk_req ? PH_EW_WALK : PH_EW_GREEN;
        end else if (ns_turn_req) begin
          adv_ph = PH_NSLT_GREEN;
        end else begin
          adv_start = 1'b1;
        end
      end
      PH_EW_WALK:    adv_ph = PH_EW_GREEN;
      PH_EW_GREEN:   adv_ph = PH_EW_YEL;
      PH_EW_YEL: begin
        if (ns_turn_req) adv_ph = PH_NSLT_GREEN;
        else adv_start = 1'b1;
      end
      PH_NSLT_GREEN: adv_ph = PH_NSLT_YEL;
      default:       adv_start = 1'b1;
    endcase
  end

  // Pick the phase for this tick and its mode
  always_comb begin
    phase_nxt = phase_r;
    day_nxt   = day_r;
    if (reload) begin
      phase_nxt = adv_ph;
      if (adv_start) day_nxt = day_new;
    end
  end

  always_comb begin
    case (phase_nxt)
      PH_NS_WALK:    ph_time = dur(cfg.ped_ns_time);
      PH_NS_GREEN:   ph_time = day_nxt ? dur(cfg.ns_green_day) : dur(NIGHT_NS_GREEN);
      PH_EWLT_GREEN: ph_time = day_nxt ? dur(cfg.left_green) : dur(cfg.ew_green_night);
      PH_EW_WALK:    ph_time = dur(cfg.ped_ew_time);
      PH_EW_GREEN:   ph_time = day_nxt ? dur(cfg.ew_green_day) : dur(cfg.ew_green_night);
      PH_NSLT_GREEN: ph_time = dur(cfg.left_green);
      default:       ph_time = dur(cfg.yellow_time);
    endcase
  end

  assign secs_cur = reload ? ph_time : secs_r;
  assign secs_nxt = secs_cur - TIME_BITS'(1);

  assign cur.phase = phase_nxt;
  assign cur.secs  = secs_cur;
  assign cur.day   = day_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      secs_r  <= '0;
      day_r   <= 1'b0;
    end else if (tick) begin
      phase_r <= phase_nxt;
      secs_r  <= secs_nxt;
      day_r   <= day_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/tss_result_enc.sv -----
// Lamp, countdown and buzzer encoding for one tick of the sequencer.
`timescale 1ns / 1ps
`default_nettype none
module tss_result_enc
  import tss_pkg::*;
(
  input  wire tss_tick_t cur,
  output tss_result_t    res
);

  logic [1:0] appr;
  logic [1:0] colour;
  logic       walk;
  logic [5:0] secs6;

  assign secs6 = 6'(cur.secs);

  always_comb begin
    appr   = APPR_EW_TURN;
    colour = LAMP_GREEN;
    walk   = 1'b0;
    case (cur.phase)
      PH_NS_WALK:    begin appr = APPR_NS;      walk = 1'b1;          end
      PH_NS_GREEN:   begin appr = APPR_NS;                            end
      PH_NS_YEL:     begin appr = APPR_NS;      colour = LAMP_YELLOW; end
      PH_EWLT_GREEN: begin appr = APPR_EW_TURN;                       end
      PH_EWLT_YEL:   begin appr = APPR_EW_TURN; colour = LAMP_YELLOW; end
      PH_EW_WALK:    begin appr = APPR_EW;      walk = 1'b1;          end
      PH_EW_GREEN:   begin appr = APPR_EW;                            end
      PH_EW_YEL:     begin appr = APPR_EW;      colour = LAMP_YELLOW; end
      PH_NSLT_GREEN: begin appr = APPR_NS_TURN;                       end
      PH_NSLT_YEL:   begin appr = APPR_NS_TURN; colour = LAMP_YELLOW; end
      default:       begin appr = APPR_EW_TURN;                       end
    endcase
  end

  always_comb begin
    res.ns_lamp        = (appr == APPR_NS)      ? colour : LAMP_RED;
    res.ns_turn_lamp   = (appr == APPR_NS_TURN) ? colour : LAMP_RED;
    res.ew_lamp        = (appr == APPR_EW)      ? colour : LAMP_RED;
    res.ew_turn_lamp   = (appr == APPR_EW_TURN) ? colour : LAMP_RED;
    res.timed_approach = appr;
    res.seconds_shown  = walk ? 6'd0 : secs6;
    res.walk_side      = walk && (cur.phase == PH_EW_WALK);
    res.walk_count     = walk ? (secs6 - 6'd1) : 6'd0;
    res.buzzer_on      = walk;
    res.day_active     = cur.day;
  end

endmodule
`default_nettype wire

// ----- sv/traffic_signal_sequencer_unit.sv -----
// Top level of the four-approach traffic signal sequencer.
//
// Usage: present one transaction on the input channel per one-second tick,
// carrying the light sensor sample and the four request switches. Each
// accepted transaction produces exactly one result transaction: four lamp
// colours, the timed approach, the green/yellow countdown, the walk side and
// countdown, the buzzer and the day/night mode of the running cycle.
// Latency: the result is valid on the cycle after the input is accepted.
// Throughput: one transaction per clock unless stalled; the phase update and
// result encoding are a single combinational pass into the result register.
// Stall: out_stall holds the result register; in_stall rises only while a
// held result is still waiting, so a new transaction is taken in the same
// cycle that the waiting result leaves.
// Reset (rst_n low, synchronous): drop any pending result, return the
// sequencer to cycle start and load the default timing registers.
// Configuration: write registers through cfg_we/cfg_index/cfg_wdata only
// while no result is outstanding.
`timescale 1ns / 1ps
`default_nettype none
module traffic_signal_sequencer_unit
  import tss_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // Configuration write port
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata,
  // Input channel
  input  wire logic                     in_valid,
  output      logic                     in_stall,
  input  wire logic [LEVEL_BITS-1:0]    in_light_level,
  input  wire logic                     in_ns_walk_req,
  input  wire logic                     in_ns_turn_req,
  input  wire logic                     in_ew_walk_req,
  input  wire logic                     in_ew_turn_req,
  // Result channel
  output      logic                     out_valid,
  input  wire logic                     out_stall,
  output      logic [1:0]               out_ns_lamp,
  output      logic [1:0]               out_ns_turn_lamp,
  output      logic [1:0]               out_ew_lamp,
  output      logic [1:0]               out_ew_turn_lamp,
  output      logic [1:0]               out_timed_approach,
  output      logic [5:0]               out_seconds_shown,
  output      logic                     out_walk_side,
  output      logic [5:0]               out_walk_count,
  output      logic                     out_buzzer_on,
  output      logic                     out_day_active
);

  tss_cfg_t    cfg_r;
  tss_tick_t   cur;
  tss_result_t res;
  tss_result_t res_r;
  logic        out_valid_r;
  logic        in_take;

  // Accept whenever the result register is empty or being emptied this cycle
  assign in_stall = out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  // Timing registers; reset loads the default plan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.day_threshold  <= LEVEL_BITS'(563);
      cfg_r.yellow_time    <= TIME_BITS'(3);
      cfg_r.ns_green_day   <= TIME_BITS'(7);
      cfg_r.ew_green_day   <= TIME_BITS'(9);
      cfg_r.ew_green_night <= TIME_BITS'(6);
      cfg_r.left_green     <= TIME_BITS'(8);
      cfg_r.ped_ns_time    <= TIME_BITS'(8);
      cfg_r.ped_ew_time    <= TIME_BITS'(9);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DAY_THRESHOLD:  cfg_r.day_threshold  <= cfg_wdata[LEVEL_BITS-1:0];
        CFG_YELLOW_TIME:    cfg_r.yellow_time    <= cfg_wdata[TIME_BITS-1:0];
        CFG_NS_GREEN_DAY:   cfg_r.ns_green_day   <= cfg_wdata[TIME_BITS-1:0];
        CFG_EW_GREEN_DAY:   cfg_r.ew_green_day   <= cfg_wdata[TIME_BITS-1:0];
        CFG_EW_GREEN_NIGHT: cfg_r.ew_green_night <= cfg_wdata[TIME_BITS-1:0];
        CFG_LEFT_GREEN:     cfg_r.left_green     <= cfg_wdata[TIME_BITS-1:0];
        CFG_PED_NS_TIME:    cfg_r.ped_ns_time    <= cfg_wdata[TIME_BITS-1:0];
        CFG_PED_EW_TIME:    cfg_r.ped_ew_time    <= cfg_wdata[TIME_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Advance the phase state once per accepted tick
  tss_phase_ctl u_phase (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick        (in_take),
    .cfg         (cfg_r),
    .light_level (in_light_level),
    .ns_walk_req (in_ns_walk_req),
    .ns_turn_req (in_ns_turn_req),
    .ew_walk_req (in_ew_walk_req),
    .ew_turn_req (in_ew_turn_req),
    .cur         (cur)
  );

  tss_result_enc u_enc (
    .cur (cur),
    .res (res)
  );

  // Result register: load on accept, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_ns_lamp        = res_r.ns_lamp;
  assign out_ns_turn_lamp   = res_r.ns_turn_lamp;
  assign out_ew_lamp        = res_r.ew_lamp;
  assign out_ew_turn_lamp   = res_r.ew_turn_lamp;
  assign out_timed_approach = res_r.timed_approach;
  assign out_seconds_shown  = res_r.seconds_shown;
  assign out_walk_side      = res_r.walk_side;
  assign out_walk_count     = res_r.walk_count;
  assign out_buzzer_on      = res_r.buzzer_on;
  assign out_day_active     = res_r.day_active;

endmodule
`default_nettype wire

// ----- sv/tss_checker.sv -----
// Port-level checks for the traffic signal sequencer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module tss_checker
  import tss_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] out_ns_lamp,
  input wire logic [1:0] out_ns_turn_lamp,
  input wire logic [1:0] out_ew_lamp,
  input wire logic [1:0] out_ew_turn_lamp,
  input wire logic [1:0] out_timed_approach,
  input wire logic [5:0] out_seconds_shown,
  input wire logic       out_walk_side,
  input wire logic [5:0] out_walk_count,
  input wire logic       out_buzzer_on,
  input wire logic       out_day_active
);

  // Every accepted transaction shows a result on the next cycle
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted transaction produced no result");

  // A held result blocks the input side
  a_stall_backs_up: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> in_stall)
    else $error("input taken while result is held");

  // Walk seconds show no green countdown and beep
  a_walk_no_countdown: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_buzzer_on) |-> (out_seconds_shown == 6'd0))
    else $error("countdown shown during walk interval");

  // Walk runs only on a green through approach on its own side
  a_walk_on_green: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_buzzer_on) |->
      ((!out_walk_side && out_ns_lamp == LAMP_GREEN) ||
       (out_walk_side && out_ew_lamp == LAMP_GREEN)))
    else $error("walk interval on an approach that is not green");

  // A stalled result holds its payload
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      ($stable(out_ns_lamp) && $stable(out_ns_turn_lamp) &&
       $stable(out_ew_lamp) && $stable(out_ew_turn_lamp) &&
       $stable(out_timed_approach) && $stable(out_seconds_shown) &&
       $stable(out_walk_side) && $stable(out_walk_count) &&
       $stable(out_buzzer_on) && $stable(out_day_active)))
    else $error("stalled result changed");

endmodule

bind traffic_signal_sequencer_unit tss_checker u_tss_checker (.*);
`default_nettype wire

// ----- test/tss_result_checker.sv -----
`timescale 1ns / 1ps
// Checker that predicts and compares every result of the traffic signal sequencer.
module tss_result_checker
  import tss_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [LEVEL_BITS-1:0]    in_light_level,
  input  logic                     in_ns_walk_req,
  input  logic                     in_ns_turn_req,
  input  logic                     in_ew_walk_req,
  input  logic                     in_ew_turn_req,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [1:0]               out_ns_lamp,
  input  logic [1:0]               out_ns_turn_lamp,
  input  logic [1:0]               out_ew_lamp,
  input  logic [1:0]               out_ew_turn_lamp,
  input  logic [1:0]               out_timed_approach,
  input  logic [5:0]               out_seconds_shown,
  input  logic                     out_walk_side,
  input  logic [5:0]               out_walk_count,
  input  logic                     out_buzzer_on,
  input  logic                     out_day_active,
  output int                       mismatches,
  output int                       pending_results,
  output int                       results_checked,
  output int                       day_cycles,
  output int                       night_cycles
);

  tss_cfg_t             timing;
  phase_t               cur_phase;
  logic [TIME_BITS-1:0] secs_left;
  logic                 day_run;
  int                   fail_total;
  int                   checked_total;
  int                   day_total;
  int                   night_total;
  tss_result_t          expected_q[$];
  tss_result_t          want;
  tss_result_t          got;
  string                bad_fields;

  function automatic logic [TIME_BITS-1:0] at_least_one(input logic [TIME_BITS-1:0] t);
    return t | TIME_BITS'(t == '0);
  endfunction

  // Pick the mode of a new cycle and its first phase
  function automatic phase_t open_cycle(input logic [LEVEL_BITS-1:0] lvl, input logic ns_walk);
    day_run = (lvl < timing.day_threshold);
    if (day_run) day_total++;
    else night_total++;
    if (day_run && ns_walk) return PH_NS_WALK;
    return PH_NS_GREEN;
  endfunction

  function automatic phase_t following(input phase_t p, input logic [LEVEL_BITS-1:0] lvl,
                                       input logic nsw, input logic nst,
                                       input logic eww, input logic ewt);
    case (p)
      PH_NS_WALK:    return PH_NS_GREEN;
      PH_NS_GREEN:   return PH_NS_YEL;
      PH_NS_YEL: begin
        if (ewt) return PH_EWLT_GREEN;
        if (day_run && eww) return PH_EW_WALK;
        return PH_EW_GREEN;
      end
      PH_EWLT_GREEN: return PH_EWLT_YEL;
      PH_EWLT_YEL: begin
        if (day_run) return eww ? PH_EW_WALK : PH_EW_GREEN;
        if (nst) return PH_NSLT_GREEN;
        return open_cycle(lvl, nsw);
      end
      PH_EW_WALK:    return PH_EW_GREEN;
      PH_EW_GREEN:   return PH_EW_YEL;
      PH_EW_YEL: begin
        if (nst) return PH_NSLT_GREEN;
        return open_cycle(lvl, nsw);
      end
      PH_NSLT_GREEN: return PH_NSLT_YEL;
      default:       return open_cycle(lvl, nsw);
    endcase
  endfunction

  function automatic logic [TIME_BITS-1:0] length_of(input phase_t p);
    case (p)
      PH_NS_WALK:    return at_least_one(timing.ped_ns_time);
      PH_NS_GREEN:   return day_run ? at_least_one(timing.ns_green_day)
                                    : at_least_one(NIGHT_NS_GREEN);
      PH_EWLT_GREEN: return day_run ? at_least_one(timing.left_green)
                                    : at_least_one(timing.ew_green_night);
      PH_EW_WALK:    return at_least_one(timing.ped_ew_time);
      PH_EW_GREEN:   return day_run ? at_least_one(timing.ew_green_day)
                                    : at_least_one(timing.ew_green_night);
      PH_NSLT_GREEN: return at_least_one(timing.left_green);
      default:       return at_least_one(timing.yellow_time);
    endcase
  endfunction

  // Advance the sequence by one tick and return the lamp picture it shows
  function automatic tss_result_t predict_tick(input logic [LEVEL_BITS-1:0] lvl,
                                               input logic nsw, input logic nst,
                                               input logic eww, input logic ewt);
    tss_result_t r;
    logic [1:0]  appr;
    logic [1:0]  colour;
    logic        walking;
    if (secs_left == '0 || cur_phase == PH_START) begin
      if (cur_phase == PH_START) cur_phase = open_cycle(lvl, nsw);
      else cur_phase = following(cur_phase, lvl, nsw, nst, eww, ewt);
      secs_left = length_of(cur_phase);
    end
    case (cur_phase)
      PH_NS_WALK, PH_NS_GREEN, PH_NS_YEL: appr = APPR_NS;
      PH_NSLT_GREEN, PH_NSLT_YEL:         appr = APPR_NS_TURN;
      PH_EW_WALK, PH_EW_GREEN, PH_EW_YEL: appr = APPR_EW;
      default:                            appr = APPR_EW_TURN;
    endcase
    colour = (cur_phase == PH_NS_YEL || cur_phase == PH_EWLT_YEL ||
              cur_phase == PH_EW_YEL || cur_phase == PH_NSLT_YEL) ? LAMP_YELLOW : LAMP_GREEN;
    walking = (cur_phase == PH_NS_WALK || cur_phase == PH_EW_WALK);
    r.ns_lamp        = (appr == APPR_NS)      ? colour : LAMP_RED;
    r.ns_turn_lamp   = (appr == APPR_NS_TURN) ? colour : LAMP_RED;
    r.ew_lamp        = (appr == APPR_EW)      ? colour : LAMP_RED;
    r.ew_turn_lamp   = (appr == APPR_EW_TURN) ? colour : LAMP_RED;
    r.timed_approach = appr;
    r.seconds_shown  = walking ? 6'd0 : 6'(secs_left);
    r.walk_side      = (cur_phase == PH_EW_WALK);
    r.walk_count     = walking ? 6'(secs_left - 1'b1) : 6'd0;
    r.buzzer_on      = walking;
    r.day_active     = day_run;
    secs_left = secs_left - 1'b1;
    return r;
  endfunction

  function automatic string show(input tss_result_t r);
    return $sformatf("lamps %0d/%0d/%0d/%0d appr %0d secs %0d walk %0d/%0d buzz %0d day %0d",
                     r.ns_lamp, r.ns_turn_lamp, r.ew_lamp, r.ew_turn_lamp,
                     r.timed_approach, r.seconds_shown, r.walk_side, r.walk_count,
                     r.buzzer_on, r.day_active);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      timing.day_threshold  = 10'd563;
      timing.yellow_time    = 6'd3;
      timing.ns_green_day   = 6'd7;
      timing.ew_green_day   = 6'd9;
      timing.ew_green_night = 6'd6;
      timing.left_green     = 6'd8;
      timing.ped_ns_time    = 6'd8;
      timing.ped_ew_time    = 6'd9;
      cur_phase   = PH_START;
      secs_left   = '0;
      day_run     = 1'b0;
      expected_q.delete();
    end else begin
      // Compare before predicting: a result never belongs to an input of the same edge
      if (out_valid && !out_stall) begin
        checked_total++;
        got.ns_lamp        = out_ns_lamp;
        got.ns_turn_lamp   = out_ns_turn_lamp;
        got.ew_lamp        = out_ew_lamp;
        got.ew_turn_lamp   = out_ew_turn_lamp;
        got.timed_approach = out_timed_approach;
        got.seconds_shown  = out_seconds_shown;
        got.walk_side      = out_walk_side;
        got.walk_count     = out_walk_count;
        got.buzzer_on      = out_buzzer_on;
        got.day_active     = out_day_active;
        if (expected_q.size() == 0) begin
          fail_total++;
          if (fail_total <= 10)
            $display("[%0t] result with nothing expected: %s", $realtime, show(got));
        end else begin
          want = expected_q.pop_front();
          bad_fields = "";
          if (got.ns_lamp !== want.ns_lamp)               bad_fields = {bad_fields, " ns_lamp"};
          if (got.ns_turn_lamp !== want.ns_turn_lamp)     bad_fields = {bad_fields, " ns_turn_lamp"};
          if (got.ew_lamp !== want.ew_lamp)               bad_fields = {bad_fields, " ew_lamp"};
          if (got.ew_turn_lamp !== want.ew_turn_lamp)     bad_fields = {bad_fields, " ew_turn_lamp"};
          if (got.timed_approach !== want.timed_approach) bad_fields = {bad_fields, " timed_approach"};
          if (got.seconds_shown !== want.seconds_shown)   bad_fields = {bad_fields, " seconds_shown"};
          if (got.walk_side !== want.walk_side)           bad_fields = {bad_fields, " walk_side"};
          if (got.walk_count !== want.walk_count)         bad_fields = {bad_fields, " walk_count"};
          if (got.buzzer_on !== want.buzzer_on)           bad_fields = {bad_fields, " buzzer_on"};
          if (got.day_active !== want.day_active)         bad_fields = {bad_fields, " day_active"};
          if (bad_fields != "") begin
            fail_total++;
            if (fail_total <= 10) begin
              $display("[%0t] mismatch in%s", $realtime, bad_fields);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(got));
            end
          end
        end
      end
      // A tick taken on this edge still sees the registers as they stood before it
      if (in_valid && !in_stall)
        expected_q.push_back(predict_tick(in_light_level, in_ns_walk_req, in_ns_turn_req,
                                          in_ew_walk_req, in_ew_turn_req));
      if (cfg_we) begin
        case (cfg_index)
          CFG_DAY_THRESHOLD:  timing.day_threshold  = cfg_wdata[LEVEL_BITS-1:0];
          CFG_YELLOW_TIME:    timing.yellow_time    = cfg_wdata[TIME_BITS-1:0];
          CFG_NS_GREEN_DAY:   timing.ns_green_day   = cfg_wdata[TIME_BITS-1:0];
          CFG_EW_GREEN_DAY:   timing.ew_green_day   = cfg_wdata[TIME_BITS-1:0];
          CFG_EW_GREEN_NIGHT: timing.ew_green_night = cfg_wdata[TIME_BITS-1:0];
          CFG_LEFT_GREEN:     timing.left_green     = cfg_wdata[TIME_BITS-1:0];
          CFG_PED_NS_TIME:    timing.ped_ns_time    = cfg_wdata[TIME_BITS-1:0];
          default:            timing.ped_ew_time    = cfg_wdata[TIME_BITS-1:0];
        endcase
      end
    end
    mismatches      <= fail_total;
    pending_results <= expected_q.size();
    results_checked <= checked_total;
    day_cycles      <= day_total;
    night_cycles    <= night_total;
  end

  initial begin
    fail_total      = 0;
    checked_total   = 0;
    day_total       = 0;
    night_total     = 0;
    mismatches      = 0;
    pending_results = 0;
    results_checked = 0;
    day_cycles      = 0;
    night_cycles    = 0;
  end

endmodule

// ----- test/traffic_signal_sequencer_unit_tb.sv -----
`timescale 1ns / 1ps
// Testbench top: stimulus, timing settings and verdict for the traffic signal sequencer.
module traffic_signal_sequencer_unit_tb;
  import tss_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int N_SETTINGS   = 8;

  // Receiver behaviour; each mode holds for a random span of cycles
  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  logic                     clk            = 1'b0;
  logic                     rst_n          = 1'b0;
  logic                     cfg_we         = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index      = CFG_DAY_THRESHOLD;
  logic [CFG_DATA_BITS-1:0] cfg_wdata      = '0;
  logic                     in_valid       = 1'b0;
  logic [LEVEL_BITS-1:0]    in_light_level = '0;
  logic                     in_ns_walk_req = 1'b0;
  logic                     in_ns_turn_req = 1'b0;
  logic                     in_ew_walk_req = 1'b0;
  logic                     in_ew_turn_req = 1'b0;
  logic                     out_stall      = 1'b0;

  logic                     in_stall;
  logic                     out_valid;
  logic [1:0]               out_ns_lamp;
  logic [1:0]               out_ns_turn_lamp;
  logic [1:0]               out_ew_lamp;
  logic [1:0]               out_ew_turn_lamp;
  logic [1:0]               out_timed_approach;
  logic [5:0]               out_seconds_shown;
  logic                     out_walk_side;
  logic [5:0]               out_walk_count;
  logic                     out_buzzer_on;
  logic                     out_day_active;

  int                       mismatches;
  int                       pending_results;
  int                       results_checked;
  int                       day_cycles;
  int                       night_cycles;

  int                       cycle_count;
  int                       ticks_sent;
  logic [LEVEL_BITS-1:0]    cur_threshold;
  rx_mode_t                 rx_mode;
  int                       rx_span;

  // Sensor samples that sit on the extremes and around the default threshold
  logic [LEVEL_BITS-1:0]    corner_levels [9] = '{10'd0, 10'd1023, 10'd562, 10'd563,
                                                  10'd564, 10'd1, 10'd1022, 10'd512, 10'd511};

  traffic_signal_sequencer_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_light_level     (in_light_level),
    .in_ns_walk_req     (in_ns_walk_req),
    .in_ns_turn_req     (in_ns_turn_req),
    .in_ew_walk_req     (in_ew_walk_req),
    .in_ew_turn_req     (in_ew_turn_req),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_ns_lamp        (out_ns_lamp),
    .out_ns_turn_lamp   (out_ns_turn_lamp),
    .out_ew_lamp        (out_ew_lamp),
    .out_ew_turn_lamp   (out_ew_turn_lamp),
    .out_timed_approach (out_timed_approach),
    .out_seconds_shown  (out_seconds_shown),
    .out_walk_side      (out_walk_side),
    .out_walk_count     (out_walk_count),
    .out_buzzer_on      (out_buzzer_on),
    .out_day_active     (out_day_active)
  );

  tss_result_checker result_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_light_level     (in_light_level),
    .in_ns_walk_req     (in_ns_walk_req),
    .in_ns_turn_req     (in_ns_turn_req),
    .in_ew_walk_req     (in_ew_walk_req),
    .in_ew_turn_req     (in_ew_turn_req),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_ns_lamp        (out_ns_lamp),
    .out_ns_turn_lamp   (out_ns_turn_lamp),
    .out_ew_lamp        (out_ew_lamp),
    .out_ew_turn_lamp   (out_ew_turn_lamp),
    .out_timed_approach (out_timed_approach),
    .out_seconds_shown  (out_seconds_shown),
    .out_walk_side      (out_walk_side),
    .out_walk_count     (out_walk_count),
    .out_buzzer_on      (out_buzzer_on),
    .out_day_active     (out_day_active),
    .mismatches         (mismatches),
    .pending_results    (pending_results),
    .results_checked    (results_checked),
    .day_cycles         (day_cycles),
    .night_cycles       (night_cycles)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Receiver: hold out_stall in one of several patterns, switching pattern now and then
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_mode = RX_FREE;
      rx_span = 0;
    end else begin
      if (rx_span == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_span = $urandom_range(8, 60);
      end
      rx_span--;
      case (rx_mode)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:  out_stall <= (rx_span % 3 == 0);
      endcase
    end
  end

  // Give up on a hung run
  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("FAIL traffic_signal_sequencer_unit");
    $finish;
  end

  // Hold off until every predicted result has left the block; the count seen at an
  // edge reflects the previous edge, so step once before looking
  task automatic wait_for_drain();
    do @(posedge clk); while (pending_results != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
  endtask

  // Write the whole timing set; junk goes into the unused top bits of the six-bit registers
  task automatic load_setting(input tss_cfg_t s);
    cur_threshold = s.day_threshold;
    write_reg(CFG_DAY_THRESHOLD,  s.day_threshold);
    write_reg(CFG_YELLOW_TIME,    {4'($urandom), s.yellow_time});
    write_reg(CFG_NS_GREEN_DAY,   {4'($urandom), s.ns_green_day});
    write_reg(CFG_EW_GREEN_DAY,   {4'($urandom), s.ew_green_day});
    write_reg(CFG_EW_GREEN_NIGHT, {4'($urandom), s.ew_green_night});
    write_reg(CFG_LEFT_GREEN,     {4'($urandom), s.left_green});
    write_reg(CFG_PED_NS_TIME,    {4'($urandom), s.ped_ns_time});
    write_reg(CFG_PED_EW_TIME,    {4'($urandom), s.ped_ew_time});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly short intervals, now and then a zero (runs as one second) or the longest
  function automatic logic [TIME_BITS-1:0] pick_time();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return TIME_BITS'(63);
    return TIME_BITS'($urandom_range(1, 6));
  endfunction

  function automatic tss_cfg_t setting_for(input int ph);
    tss_cfg_t s;
    s.day_threshold  = 10'($urandom_range(0, 1023));
    s.yellow_time    = pick_time();
    s.ns_green_day   = pick_time();
    s.ew_green_day   = pick_time();
    s.ew_green_night = pick_time();
    s.left_green     = pick_time();
    s.ped_ns_time    = pick_time();
    s.ped_ew_time    = pick_time();
    case (ph)
      0: begin
        // Every interval collapses to one second, so each tick moves the sequence on
        s = '0;
        s.day_threshold = 10'd563;
      end
      1: begin
        s.day_threshold  = 10'd563;
        s.yellow_time    = 6'd3;
        s.ns_green_day   = 6'd7;
        s.ew_green_day   = 6'd9;
        s.ew_green_night = 6'd6;
        s.left_green     = 6'd8;
        s.ped_ns_time    = 6'd8;
        s.ped_ew_time    = 6'd9;
      end
      2: begin
        // No sample is below zero: night cycles only
        s.day_threshold  = '0;
        s.yellow_time    = TIME_BITS'($urandom_range(1, 5));
        s.ew_green_night = TIME_BITS'($urandom_range(1, 5));
        s.left_green     = TIME_BITS'($urandom_range(1, 5));
      end
      3: begin
        s.day_threshold  = 10'd1023;
        s.yellow_time    = 6'd63;
        s.ns_green_day   = 6'd63;
        s.ew_green_day   = 6'd63;
        s.ew_green_night = 6'd63;
        s.left_green     = 6'd63;
        s.ped_ns_time    = 6'd63;
        s.ped_ew_time    = 6'd63;
      end
      default: ;
    endcase
    return s;
  endfunction

  // Present one tick and hold it until the block takes it
  task automatic send_tick(input logic [LEVEL_BITS-1:0] lvl, input logic [3:0] reqs);
    in_valid       <= 1'b1;
    in_light_level <= lvl;
    in_ns_walk_req <= reqs[3];
    in_ns_turn_req <= reqs[2];
    in_ew_walk_req <= reqs[1];
    in_ew_turn_req <= reqs[0];
    do @(posedge clk); while (in_stall);
    ticks_sent++;
  endtask

  // Send n ticks in bursts; the directed set walks the sensor corners and request
  // patterns, the random set leans on samples near the threshold
  task automatic run_ticks(input int n, input bit directed, input bit pause_mid);
    int                    k;
    int                    burst;
    int                    gap;
    int                    near;
    int                    sel;
    logic [LEVEL_BITS-1:0] lvl;
    logic [3:0]            reqs;
    burst = $urandom_range(1, 8);
    for (k = 0; k < n; k++) begin
      if (directed) begin
        lvl  = corner_levels[k % 9];
        reqs = (k % 2 == 1) ? 4'hF : 4'(k / 2);
      end else begin
        sel = $urandom_range(0, 9);
        if (sel < 4) begin
          lvl = 10'($urandom_range(0, 1023));
        end else if (sel < 8) begin
          near = $urandom_range(0, 6);
          near = near + int'(cur_threshold) - 3;
          if (near < 0) near = 0;
          if (near > 1023) near = 1023;
          lvl = 10'(near);
        end else begin
          lvl = (sel == 8) ? 10'd0 : 10'd1023;
        end
        reqs = 4'($urandom);
      end
      send_tick(lvl, reqs);
      if (k == n - 1) begin
        in_valid <= 1'b0;
      end else if (pause_mid && k == n / 2) begin
        // Stop the sender until the block has nothing left in flight
        in_valid <= 1'b0;
        wait_for_drain();
      end else begin
        burst--;
        if (burst == 0) begin
          sel   = $urandom_range(0, 9);
          gap   = (sel < 3) ? 0 : (sel < 8) ? $urandom_range(1, 3) : $urandom_range(4, 10);
          burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
          if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
      end
    end
  endtask

  initial begin
    int ph;
    ticks_sent = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    for (ph = 0; ph < N_SETTINGS; ph++) begin
      load_setting(setting_for(ph));
      case (ph)
        0:       run_ticks(25, 1'b1, 1'b0);
        1:       run_ticks(90, 1'b0, 1'b0);
        2:       run_ticks(60, 1'b0, 1'b0);
        4:       run_ticks(75, 1'b0, 1'b1);
        default: run_ticks(75, 1'b0, 1'b0);
      endcase
      // Let the last result out, then a few more cycles before touching the registers
      wait_for_drain();
      repeat (4) @(posedge clk);
    end
    $display("Sent %0d ticks under %0d timing settings, %0d results compared.",
             ticks_sent, N_SETTINGS, results_checked);
    $display("Cycles opened: %0d day, %0d night; %0d mismatches.",
             day_cycles, night_cycles, mismatches);
    if (mismatches == 0) begin
      $display("PASS traffic_signal_sequencer_unit");
    end else begin
      $display("FAIL traffic_signal_sequencer_unit");
    end
    $finish;
  end

endmodule
